@@ hw/rtl/mnb_pkg.sv @@
// ----------------------------------------------------------------------------
// mnb_pkg
// Shared types, constants and helpers of the map neuron bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mnb_pkg;

    localparam int NEURONS_DEF = 16384;
    localparam int IDX_W       = 14;
    localparam int Q_W         = 32;
    localparam int MA_W        = 29;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_NW      = 51;
    localparam int DEN_W       = 34;

    localparam logic signed [Q_W-1:0] Q_ONE   = 32'sd16777216;
    localparam logic signed [Q_W-1:0] Q_HALF  = 32'sd8388608;
    localparam logic signed [Q_W-1:0] Q_MAX   = 32'sh7fffffff;
    localparam logic signed [Q_W-1:0] Q_MIN   = 32'sh80000000;
    localparam logic signed [Q_W-1:0] K_ALPHA = 32'sd61236838;
    localparam logic signed [Q_W-1:0] K_L     = 32'sd671089;

    localparam logic signed [MA_W-1:0] K_MU = 29'sd839;
    localparam logic signed [MA_W-1:0] K_GD = 29'sd16609444;
    localparam logic signed [MA_W-1:0] K_AD = 29'sd13421773;
    localparam logic signed [MA_W-1:0] K_GH = 29'sd16774699;

    localparam logic [24:0] NOISE_DECAY_RST      = 25'd14201695;
    localparam logic [24:0] NOISE_SCALE_RST      = 25'd89325;
    localparam logic [27:0] NOISE_DRIVE_GAIN_RST = 28'd1677722;
    localparam logic [27:0] NOISE_BIAS_GAIN_RST  = 28'd16777216;
    localparam logic [27:0] INPUT_BIAS_GAIN_RST  = 28'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_DECAY      = 3'd0,
        CFG_NOISE_SCALE      = 3'd1,
        CFG_NOISE_DRIVE_GAIN = 3'd2,
        CFG_NOISE_BIAS_GAIN  = 3'd3,
        CFG_INPUT_BIAS_GAIN  = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        FUNC_INIT = 1'b0,
        FUNC_STEP = 1'b1
    } func_t;

    typedef struct packed {
        logic                  func;
        logic [IDX_W-1:0]      neuron;
        logic [1:0]            cell_class;
        logic signed [Q_W-1:0] excitability;
        logic signed [Q_W-1:0] stim_now;
        logic signed [Q_W-1:0] stim_prev;
        logic signed [Q_W-1:0] noise_sample;
    } item_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]      neuron_out;
        logic                  spike;
        logic signed [Q_W-1:0] fast_value;
    } item_out_t;

    typedef struct packed {
        logic [1:0]            cls;
        logic signed [Q_W-1:0] sigma;
        logic signed [Q_W-1:0] fast_prev;
        logic signed [Q_W-1:0] slow_var;
        logic signed [Q_W-1:0] noise_state;
        logic signed [Q_W-1:0] input_filt;
        logic signed [Q_W-1:0] fast_adapt;
        logic signed [Q_W-1:0] slow_adapt;
        logic signed [Q_W-1:0] history_filt;
    } nstate_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [39:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = Q_MAX;
        end else if (v < -40'sd2147483648) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [Q_W-1:0] add_sat(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        return sat_q(40'(a) + 40'(b));
    endfunction

    function automatic logic signed [MA_W-1:0] gs_of(input logic [1:0] cls);
        logic signed [MA_W-1:0] r;
        unique case (cls)
            2'd0:    r = 29'sd16760439;
            2'd1:    r = 29'sd16693330;
            default: r = 29'sd16743662;
        endcase
        return r;
    endfunction

    function automatic logic signed [MA_W-1:0] k_of(input logic [1:0] cls);
        logic signed [MA_W-1:0] r;
        unique case (cls)
            2'd0:    r = 29'sd1342;
            2'd1:    r = 29'sd3272;
            2'd2:    r = -29'sd671;
            default: r = -29'sd1342;
        endcase
        return r;
    endfunction

    function automatic logic signed [MA_W-1:0] bi_of(input logic [1:0] cls);
        logic signed [MA_W-1:0] r;
        unique case (cls)
            2'd0:    r = 29'sd167772;
            2'd3:    r = 29'sd3355443;
            default: r = 29'sd1677722;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mnb_mem.sv @@
// ----------------------------------------------------------------------------
// mnb_mem
// Neuron state memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mnb_mem #(
    parameter int NEURONS = mnb_pkg::NEURONS_DEF,
    parameter int AW      = 14
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire mnb_pkg::nstate_t wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output mnb_pkg::nstate_t      rdata
);

    mnb_pkg::nstate_t mem [NEURONS];
    mnb_pkg::nstate_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mnb_mul.sv @@
// ----------------------------------------------------------------------------
// mnb_mul
// Two-stage Q8.24 multiplier with round half up and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mnb_mul (
    input  wire logic                                clk,
    input  wire logic signed [mnb_pkg::MA_W-1:0]     a,
    input  wire logic signed [mnb_pkg::Q_W-1:0]      b,
    output logic signed [mnb_pkg::Q_W-1:0]           res
);

    localparam int PW = mnb_pkg::MA_W + mnb_pkg::Q_W;

    logic signed [PW-1:0]          prod_reg;
    logic signed [PW:0]            rounded;
    logic signed [mnb_pkg::Q_W-1:0] res_reg;

    // floor shift after adding half an lsb
    assign rounded = (PW+1)'(prod_reg) + (PW+1)'(64'sd8388608);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        res_reg  <= mnb_pkg::sat_q(40'(signed'(rounded[PW:24])));
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mnb_div.sv @@
// ----------------------------------------------------------------------------
// mnb_div
// Radix-2 restoring divider for alpha / den, rounded and saturated to Q8.24.
// ----------------------------------------------------------------------------
`default_nettype none

module mnb_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [mnb_pkg::DEN_W-1:0]   den,
    output logic                                    done,
    output logic signed [mnb_pkg::Q_W-1:0]          quot
);

    localparam int NW    = mnb_pkg::DIV_NW;
    localparam int MW    = mnb_pkg::DEN_W - 1;
    localparam int CNT_W = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM = NW'(64'h8000_0000);

    logic [NW-1:0]    nq_reg;
    logic [MW-1:0]    rem_reg;
    logic [MW-1:0]    m_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [mnb_pkg::DEN_W-1:0] mag;
    logic [MW:0]               r2;
    logic                      ge;

    assign mag = den[mnb_pkg::DEN_W-1] ? mnb_pkg::DEN_W'(-den) : mnb_pkg::DEN_W'(den);
    assign r2  = {rem_reg, nq_reg[NW-1]};
    assign ge  = (r2 >= {1'b0, m_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= (den != '0);
            done_reg <= (den == '0);
            cnt_reg  <= CNT_W'(NW);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= den[mnb_pkg::DEN_W-1];
            zero_reg <= (den == '0);
            m_reg    <= mag[MW-1:0];
            rem_reg  <= '0;
            // numerator is alpha << 24 plus half the divisor for rounding
            nq_reg   <= (NW'(mnb_pkg::K_ALPHA) << 24) + NW'(mag[MW-1:1]);
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? MW'(r2 - {1'b0, m_reg}) : r2[MW-1:0];
            nq_reg  <= {nq_reg[NW-2:0], ge};
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            quot = mnb_pkg::Q_MAX;
        end
        else if (neg_reg)
        begin
            quot = (nq_reg > LIM) ? mnb_pkg::Q_MIN : mnb_pkg::Q_W'(-nq_reg[mnb_pkg::Q_W-1:0]);
        end
        else
        begin
            quot = (nq_reg >= LIM) ? mnb_pkg::Q_MAX : signed'(nq_reg[mnb_pkg::Q_W-1:0]);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/map_neuron_bank_step_top.sv @@
// ----------------------------------------------------------------------------
// map_neuron_bank_step_top
// Bank of fast/slow map neurons with per-neuron state held in one memory.
// Commands: raise start with cmd while busy is low; the item is taken at that
// edge and busy rises. An init item sets a neuron's class and sigma and clears
// its filters; a step item advances the neuron by one time step.
// Each item gives one result on result, marked by result_valid for one cycle,
// in the first cycle with busy low. The receiver cannot stall it.
// Init items, and steps whose previous fast value is below -0.5, wait for
// the 51-iteration alpha/(1-x) divider (started in the cycle after accept);
// the multiplies of a step run under it. Other steps run only their
// multiplies: nine for classes 1 to 3, or twelve and the offset state for
// class 0. An out-of-range neuron index returns a zero result.
// One item at a time: the next item can be taken while the result is shown.
// Configuration: cfg_valid/cfg_ready write channel, always ready.
// Reset: control, result and config registers return to defaults; neuron state is undefined until init.
// ----------------------------------------------------------------------------
`default_nettype none

module map_neuron_bank_step_top #(
    parameter int NEURONS = mnb_pkg::NEURONS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire mnb_pkg::item_in_t                 cmd,
    output logic                                   result_valid,
    output mnb_pkg::item_out_t                     result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mnb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mnb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int RW  = ($clog2(NEURONS + 1) > mnb_pkg::IDX_W) ?
                         $clog2(NEURONS + 1) : mnb_pkg::IDX_W;
    localparam int QW  = mnb_pkg::Q_W;
    localparam int MAW = mnb_pkg::MA_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RANGE, S_INIT, S_INIT_WAIT,
        S_XI_A, S_XI_B, S_ID_A, S_ID_B, S_HP, S_IP_A, S_IP_B, S_CUR0,
        S_CI_A, S_CI_B, S_BN_A, S_BN_B, S_SG_A, S_SG_B, S_Y, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] ph_reg;

    logic [24:0] noise_decay_reg, noise_scale_reg;
    logic [27:0] noise_drive_gain_reg, noise_bias_gain_reg, input_bias_gain_reg;

    mnb_pkg::item_in_t  cmd_reg;
    mnb_pkg::item_out_t result_reg;
    logic               result_valid_reg;

    logic signed [QW-1:0] t_reg, xi_reg, id_reg, hp_reg, ip_reg, cur_reg;
    logic signed [QW-1:0] bn_reg, sg_reg, y_reg, x_reg;

    mnb_pkg::nstate_t old, wdata;
    logic             mem_we, mem_re, accept, in_range;

    logic signed [MAW-1:0] mul_a;
    logic signed [QW-1:0]  mul_b, mul_res;
    logic                  mul_state, ph_last;

    logic                              div_start, div_done;
    logic signed [mnb_pkg::DEN_W-1:0]  div_den;
    logic signed [QW-1:0]              div_q;

    logic signed [QW-1:0] d_now, x_init, im, idpos, s_y, x_step, y_init;
    logic                 xneg, fin_ok;
    logic [1:0]           cls;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = (RW'(cmd.neuron) < RW'(NEURONS));
    assign mem_re    = accept;
    assign cls       = old.cls;

    assign d_now  = mnb_pkg::sat_q(40'(cmd_reg.stim_now) - 40'(cmd_reg.stim_prev));
    assign x_init = mnb_pkg::sat_q(40'(cmd_reg.excitability) - 40'(mnb_pkg::Q_ONE));
    assign xneg   = (old.fast_prev < -mnb_pkg::Q_HALF);
    assign idpos  = (id_reg > 0) ? id_reg : '0;
    assign im     = mnb_pkg::sat_q(40'(ip_reg) - 40'(idpos));
    assign s_y    = mnb_pkg::sat_q(40'(old.fast_prev) + 40'(mnb_pkg::Q_ONE)
                                   - 40'(old.sigma) - 40'(sg_reg));
    assign y_init = mnb_pkg::sat_q(40'(x_reg) - 40'(div_q));
    assign fin_ok = !xneg || div_done;

    always_comb
    begin
        if (xneg)
        begin
            x_step = mnb_pkg::add_sat(mnb_pkg::add_sat(div_q, old.slow_var), bn_reg);
        end
        else if (old.fast_prev < mnb_pkg::Q_ONE)
        begin
            x_step = mnb_pkg::Q_ONE;
        end
        else
        begin
            x_step = -mnb_pkg::Q_ONE;
        end
    end

    // divider: init uses 1 - x of the new sigma, step uses 1 - previous x
    always_comb
    begin
        div_start = 1'b0;
        div_den   = '0;
        if (state_reg == S_INIT)
        begin
            div_start = 1'b1;
            div_den   = mnb_pkg::DEN_W'(mnb_pkg::Q_ONE) - mnb_pkg::DEN_W'(x_init);
        end
        else if (state_reg == S_XI_A && ph_reg == 2'd0 && xneg)
        begin
            div_start = 1'b1;
            div_den   = mnb_pkg::DEN_W'(mnb_pkg::Q_ONE) - mnb_pkg::DEN_W'(old.fast_prev);
        end
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_state = 1'b1;
        unique case (state_reg)
            S_XI_A:
            begin
                mul_a = MAW'(noise_decay_reg);
                mul_b = old.noise_state;
            end
            S_XI_B:
            begin
                mul_a = MAW'(noise_scale_reg);
                mul_b = cmd_reg.noise_sample;
            end
            S_ID_A:
            begin
                mul_a = mnb_pkg::K_GD;
                mul_b = old.fast_adapt;
            end
            S_ID_B:
            begin
                mul_a = mnb_pkg::K_AD;
                mul_b = d_now;
            end
            S_HP:
            begin
                mul_a = mnb_pkg::K_GH;
                mul_b = old.history_filt;
            end
            S_IP_A:
            begin
                mul_a = mnb_pkg::gs_of(2'd0);
                mul_b = old.slow_adapt;
            end
            S_IP_B:
            begin
                mul_a = mnb_pkg::k_of(2'd0);
                mul_b = hp_reg;
            end
            S_CI_A:
            begin
                mul_a = mnb_pkg::gs_of(cls);
                mul_b = old.input_filt;
            end
            S_CI_B:
            begin
                mul_a = mnb_pkg::k_of(cls);
                mul_b = cmd_reg.stim_now;
            end
            S_BN_A:
            begin
                mul_a = MAW'(noise_drive_gain_reg);
                mul_b = xi_reg;
            end
            S_BN_B:
            begin
                mul_a = mnb_pkg::bi_of(cls);
                mul_b = cur_reg;
            end
            S_SG_A:
            begin
                mul_a = MAW'(noise_bias_gain_reg);
                mul_b = xi_reg;
            end
            S_SG_B:
            begin
                mul_a = MAW'(input_bias_gain_reg);
                mul_b = cur_reg;
            end
            S_Y:
            begin
                mul_a = mnb_pkg::K_MU;
                mul_b = s_y;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
    end

    assign ph_last = mul_state && (ph_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        priority case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_range)
                    begin
                        state_next = S_RANGE;
                    end
                    else if (cmd.func == mnb_pkg::FUNC_INIT)
                    begin
                        state_next = S_INIT;
                    end
                    else
                    begin
                        state_next = S_XI_A;
                    end
                end
            end
            S_RANGE:     state_next = S_IDLE;
            S_INIT:      state_next = S_INIT_WAIT;
            S_INIT_WAIT: state_next = div_done ? S_IDLE : S_INIT_WAIT;
            S_CUR0:      state_next = S_BN_A;
            S_FIN:       state_next = fin_ok ? S_IDLE : S_FIN;
            default:
            begin
                if (ph_last)
                begin
                    unique case (state_reg)
                        S_XI_A:  state_next = S_XI_B;
                        S_XI_B:  state_next = (cls == 2'd0) ? S_ID_A : S_CI_A;
                        S_ID_A:  state_next = S_ID_B;
                        S_ID_B:  state_next = S_HP;
                        S_HP:    state_next = S_IP_A;
                        S_IP_A:  state_next = S_IP_B;
                        S_IP_B:  state_next = S_CUR0;
                        S_CI_A:  state_next = S_CI_B;
                        S_CI_B:  state_next = S_BN_A;
                        S_BN_A:  state_next = S_BN_B;
                        S_BN_B:  state_next = S_SG_A;
                        S_SG_A:  state_next = S_SG_B;
                        S_SG_B:  state_next = S_Y;
                        default: state_next = S_FIN;
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        wdata  = old;
        if (state_reg == S_INIT_WAIT)
        begin
            mem_we       = div_done;
            wdata        = '0;
            wdata.cls    = cmd_reg.cell_class;
            wdata.sigma  = cmd_reg.excitability;
            wdata.fast_prev = x_reg;
            wdata.slow_var  = y_init;
        end
        else if (state_reg == S_FIN)
        begin
            mem_we            = fin_ok;
            wdata.fast_prev   = x_step;
            wdata.slow_var    = y_reg;
            wdata.noise_state = xi_reg;
            wdata.input_filt  = cur_reg;
            if (cls == 2'd0)
            begin
                wdata.fast_adapt   = id_reg;
                wdata.slow_adapt   = ip_reg;
                wdata.history_filt = hp_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            ph_reg               <= '0;
            result_valid_reg     <= 1'b0;
            result_reg           <= '0;
            noise_decay_reg      <= mnb_pkg::NOISE_DECAY_RST;
            noise_scale_reg      <= mnb_pkg::NOISE_SCALE_RST;
            noise_drive_gain_reg <= mnb_pkg::NOISE_DRIVE_GAIN_RST;
            noise_bias_gain_reg  <= mnb_pkg::NOISE_BIAS_GAIN_RST;
            input_bias_gain_reg  <= mnb_pkg::INPUT_BIAS_GAIN_RST;
        end
        else
        begin
            state_reg        <= state_next;
            ph_reg           <= (mul_state && !ph_last) ? ph_reg + 2'd1 : 2'd0;
            result_valid_reg <= (state_reg == S_RANGE)
                             || (state_reg == S_INIT_WAIT && div_done)
                             || (state_reg == S_FIN && fin_ok);
            if (state_reg == S_RANGE)
            begin
                result_reg.neuron_out <= cmd_reg.neuron;
                result_reg.spike      <= 1'b0;
                result_reg.fast_value <= '0;
            end
            else if (state_reg == S_INIT_WAIT)
            begin
                result_reg.neuron_out <= cmd_reg.neuron;
                result_reg.spike      <= 1'b0;
                result_reg.fast_value <= x_reg;
            end
            else if (state_reg == S_FIN)
            begin
                result_reg.neuron_out <= cmd_reg.neuron;
                result_reg.spike      <= !xneg && (old.fast_prev < mnb_pkg::Q_ONE);
                result_reg.fast_value <= x_step;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mnb_pkg::CFG_NOISE_DECAY:      noise_decay_reg      <= cfg_data[24:0];
                    mnb_pkg::CFG_NOISE_SCALE:      noise_scale_reg      <= cfg_data[24:0];
                    mnb_pkg::CFG_NOISE_DRIVE_GAIN: noise_drive_gain_reg <= cfg_data[27:0];
                    mnb_pkg::CFG_NOISE_BIAS_GAIN:  noise_bias_gain_reg  <= cfg_data[27:0];
                    mnb_pkg::CFG_INPUT_BIAS_GAIN:  input_bias_gain_reg  <= cfg_data[27:0];
                    default:                       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_INIT)
        begin
            x_reg <= x_init;
        end
        if (ph_last)
        begin
            unique case (state_reg)
                S_XI_B:  xi_reg  <= mnb_pkg::sat_q(40'(t_reg) - 40'(mul_res));
                S_ID_B:  id_reg  <= mnb_pkg::add_sat(t_reg, mul_res);
                S_HP:    hp_reg  <= mnb_pkg::add_sat(mul_res, d_now);
                S_IP_B:  ip_reg  <= mnb_pkg::add_sat(t_reg, mul_res);
                S_CI_B:  cur_reg <= mnb_pkg::add_sat(t_reg, mul_res);
                S_BN_B:  bn_reg  <= mnb_pkg::add_sat(t_reg, mul_res);
                S_SG_B:  sg_reg  <= mnb_pkg::add_sat(t_reg, mul_res);
                S_Y:     y_reg   <= mnb_pkg::sat_q(40'(old.slow_var) - 40'(mul_res));
                default: t_reg   <= mul_res;
            endcase
        end
        if (state_reg == S_CUR0)
        begin
            // rectified offset: keep the current only above minus L
            cur_reg <= ((40'(im) + 40'(mnb_pkg::K_L)) > 40'sd0) ? im : '0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    mnb_mem #(
        .NEURONS (NEURONS),
        .AW      (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(cmd_reg.neuron)),
        .wdata (wdata),
        .re    (mem_re),
        .raddr (AW'(cmd.neuron)),
        .rdata (old)
    );

    mnb_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .res (mul_res)
    );

    mnb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mnb_checker.sv @@
// ----------------------------------------------------------------------------
// mnb_props
// Port-level checks of the map neuron bank command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module mnb_props (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // an accepted item raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // every fall of busy comes with a result
    a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without a result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write held off");

endmodule

bind map_neuron_bank_step_top mnb_props u_mnb_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
